/* hdl/gfp_pkg.sv */
// Shared types, constants and scaling functions of the gyro frame parser.
package gfp_pkg;

    localparam int BYTE_W = 8;
    localparam int RAW_W  = 16;
    localparam int RATE_W = 20;
    localparam int YAW_W  = 17;
    localparam int CNT_W  = 3;

    localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'h5A;
    localparam logic [BYTE_W-1:0] TYPE_RATE = 8'hAA;
    localparam logic [BYTE_W-1:0] TYPE_YAW  = 8'hBB;

    localparam logic KIND_RATE = 1'b0;
    localparam logic KIND_YAW  = 1'b1;

    localparam logic [CNT_W-1:0] CNT_CHECKSUM = 3'd4;

    // One byte request between the input register and the decoder
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_byte_req;

    // raw * 2000 / 32768 in Q8 is raw * 125 / 8; drop the 3 low bits for the floor
    function automatic logic signed [RATE_W-1:0] scale_rate(input logic [RAW_W-1:0] raw);
        logic [23:0] prod;
        prod = {{8{raw[RAW_W-1]}}, raw} * 24'd125;
        return $signed(prod[22:3]);
    endfunction

    // raw * 180 / 32768 in Q8 is raw * 45 / 32; drop the 5 low bits for the floor
    function automatic logic signed [YAW_W-1:0] scale_yaw(input logic [RAW_W-1:0] raw);
        logic [22:0] prod;
        prod = {{7{raw[RAW_W-1]}}, raw} * 23'd45;
        return $signed(prod[21:5]);
    endfunction

endpackage

/* hdl/gfp_if.sv */
// Stream interfaces of the gyro frame parser: received bytes and decoded results.
interface gfp_byte_if;
    import gfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gfp_res_if;
    import gfp_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     frame_kind;
    logic signed [RATE_W-1:0] rate_q8;
    logic signed [YAW_W-1:0]  yaw_q8;
    modport source (output valid, output frame_kind, output rate_q8, output yaw_q8,
                    input ready);
    modport sink   (input valid, input frame_kind, input rate_q8, input yaw_q8,
                    output ready);
endinterface

/* hdl/gfp_in_stage.sv */
// Input register: captures one received byte and hands it to the decoder.
module gfp_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gfp_byte_if.sink           i_byte,
    input  logic               i_advance,
    output gfp_pkg::t_byte_req o_req
);
    import gfp_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_ready;

    // take a new byte when the register is empty or drains this cycle
    assign w_ready      = !r_valid || i_advance;
    assign i_byte.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_byte.valid;
        end
    end

    // hold the payload until the decoder takes it
    always_ff @(posedge i_clk) begin
        if (w_ready && i_byte.valid) begin
            r_byte <= i_byte.rx_byte;
        end
    end

    assign o_req.valid = r_valid;
    assign o_req.data  = r_byte;

endmodule

/* hdl/gfp_decoder.sv */
// Frame assembly, checksum test, scaling and the result register.
module gfp_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gfp_pkg::t_byte_req i_req,
    output logic               o_advance,
    gfp_res_if.source          o_res
);
    import gfp_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic [BYTE_W-1:0]        r_store [4];
    logic signed [RATE_W-1:0] r_rate_q8;
    logic signed [YAW_W-1:0]  r_yaw_q8;
    logic                     r_out_valid;
    logic                     r_out_kind;
    logic signed [RATE_W-1:0] r_out_rate;
    logic signed [YAW_W-1:0]  r_out_yaw;

    logic                     w_take;
    logic [CNT_W-1:0]         n_count;
    logic                     n_emit;
    logic                     w_store_en;
    logic                     w_is_rate;
    logic                     w_is_yaw;
    logic [BYTE_W-1:0]        w_sum;
    logic [RAW_W-1:0]         w_val;
    logic signed [RATE_W-1:0] n_rate_q8;
    logic signed [YAW_W-1:0]  n_yaw_q8;

    // advance when the result register is free or being taken
    assign o_advance = !r_out_valid || o_res.ready;
    assign w_take    = o_advance && i_req.valid;

    // checksum over the stored frame bytes, type from the stored type byte
    assign w_is_rate = (r_store[1] == TYPE_RATE);
    assign w_is_yaw  = (r_store[1] == TYPE_YAW);
    assign w_sum     = r_store[0] + r_store[1] + r_store[2] + r_store[3];
    assign w_val     = {r_store[3], r_store[2]};

    // step the byte count; resync only on the header slot
    always_comb begin
        n_count    = r_count;
        n_emit     = 1'b0;
        w_store_en = 1'b0;
        n_rate_q8  = r_rate_q8;
        n_yaw_q8   = r_yaw_q8;
        if (r_count == CNT_CHECKSUM) begin
            n_count = '0;
            if ((w_is_rate || w_is_yaw) && (w_sum == i_req.data)) begin
                n_emit = 1'b1;
                if (w_is_rate) begin
                    n_rate_q8 = scale_rate(w_val);
                end else begin
                    n_yaw_q8 = scale_yaw(w_val);
                end
            end
        end else if ((r_count != '0) || (i_req.data == HDR_BYTE)) begin
            w_store_en = 1'b1;
            n_count    = r_count + 3'd1;
        end
    end

    // control state and latest scaled values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rate_q8   <= '0;
            r_yaw_q8    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count   <= n_count;
                r_rate_q8 <= n_rate_q8;
                r_yaw_q8  <= n_yaw_q8;
            end
            if (o_advance) begin
                r_out_valid <= w_take && n_emit;
            end
        end
    end

    // frame bytes and result payload
    always_ff @(posedge i_clk) begin
        if (w_take && w_store_en) begin
            r_store[r_count[1:0]] <= i_req.data;
        end
        if (w_take && n_emit) begin
            r_out_kind <= w_is_rate ? KIND_RATE : KIND_YAW;
            r_out_rate <= n_rate_q8;
            r_out_yaw  <= n_yaw_q8;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.frame_kind = r_out_kind;
    assign o_res.rate_q8    = r_out_rate;
    assign o_res.yaw_q8     = r_out_yaw;

endmodule

/* hdl/gyro_frame_parser_top.sv */
// Top level of the gyro frame parser.
//
// Usage:
//   i_byte carries received serial bytes, one per request (valid/ready).
//   o_res carries one decoded result per good frame: the frame kind
//   (0 rate, 1 yaw) and the latest rate and yaw in signed Q8.
//   Frames are 5 bytes: 0x5A, type, value low, value high, 8-bit sum.
//   Bad checksums and unknown types are dropped without a result.
// Timing:
//   A byte passes an input register and then the decoder into the result
//   register, where the result of a frame's last byte shows. One byte is
//   taken every cycle while the receiver does not stall o_res.
// Reset (synchronous, active low) empties both registers, clears the byte
// count and sets both latest values to zero.
// When the receiver stalls, the result register holds; one more byte waits
// in the input register and then i_byte.ready drops.
module gyro_frame_parser_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gfp_byte_if.sink  i_byte,
    gfp_res_if.source o_res
);
    import gfp_pkg::*;

    t_byte_req w_req;
    logic      w_advance;

    gfp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (w_advance),
        .o_req     (w_req)
    );

    gfp_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_advance (w_advance),
        .o_res     (o_res)
    );

endmodule

/* hdl/gfp_checker.sv */
// Port-level checker of the gyro frame parser and its binding to the top level.
module gfp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic                             i_out_kind,
    input logic signed [gfp_pkg::RATE_W-1:0] i_out_rate,
    input logic signed [gfp_pkg::YAW_W-1:0]  i_out_yaw
);
    import gfp_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // stalled result keeps valid and payload
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled result dropped");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_kind) && $stable(i_out_rate) && $stable(i_out_yaw))
        else $error("stalled result changed");

    // an idle result register never blocks the input
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output empty");

    // a rate frame leaves the yaw of the previous result alone
    a_rate_keeps_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) ##1 (i_out_valid && (i_out_kind == KIND_RATE))
            |-> (i_out_yaw == $past(i_out_yaw)))
        else $error("rate frame changed yaw");

endmodule

bind gyro_frame_parser_top gfp_checker u_gfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.frame_kind),
    .i_out_rate  (o_res.rate_q8),
    .i_out_yaw   (o_res.yaw_q8)
);
